[rtl/ordered_list_delete_engine_defines.svh]
// assertion macros for the ordered list delete engine
`ifndef ORDERED_LIST_DELETE_ENGINE_DEFINES_SVH
`define ORDERED_LIST_DELETE_ENGINE_DEFINES_SVH

`ifndef ASSERT_OFF
// antecedent implies consequent in the same cycle
`define OLDE_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);
// antecedent implies consequent in the next cycle
`define OLDE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define OLDE_ASSERT_IMP(label, ante, cons, msg)
`define OLDE_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

[rtl/olde_pkg.sv]
// shared types, codes and constants of the ordered list delete engine
package olde_pkg;

    // word field widths
    localparam int CMD_W    = 3;
    localparam int DATA_W   = 32;
    localparam int POS_W    = 6;
    localparam int STATUS_W = 2;
    localparam int ENTRY_W  = 7;

    // positions are 6 bits, so the list never holds more than this
    localparam int MAX_CAPACITY       = 64;
    localparam int LIST_DEPTH_DEFAULT = 64;

    // command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_APPEND     = 3'd0,
        CMD_DEL_VALUE  = 3'd1,
        CMD_DEL_POS    = 3'd2,
        CMD_READ_POS   = 3'd3,
        CMD_CLEAR      = 3'd4
    } cmd_t;

    // status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_DONE = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } status_t;

    // controller states
    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_SCAN  = 3'b010,
        S_APPLY = 3'b100
    } state_t;

    // broadcast control from the controller to every cell
    typedef struct packed {
        logic by_value;   // compare against the key rather than the position
        logic scan;       // capture the match flag
        logic delete_en;  // cells in the shift mask take their neighbour's word
        logic append_en;  // the cell at the tail takes the key
    } cell_ctrl_t;

endpackage

[rtl/olde_cell.sv]
// one list cell: holds an entry, compares it and shifts it down on delete
module olde_cell #(
    parameter int CELL_INDEX = 0,
    parameter int COUNT_W    = 7
) (
    input  logic                        aclk,
    input  olde_pkg::cell_ctrl_t        ctrl,
    input  logic [COUNT_W-1:0]          count,
    input  logic [olde_pkg::DATA_W-1:0] key,
    input  logic [olde_pkg::POS_W-1:0]  pos,
    input  logic                        shift_en,
    input  logic [olde_pkg::DATA_W-1:0] upper_value,
    output logic [olde_pkg::DATA_W-1:0] value,
    output logic                        match
);

    logic [olde_pkg::DATA_W-1:0] value_reg;
    logic                        match_reg;
    logic                        in_list;
    logic                        at_tail;
    logic                        match_next;

    // occupancy of this slot
    assign in_list = COUNT_W'(CELL_INDEX) < count;
    assign at_tail = COUNT_W'(CELL_INDEX) == count;

    // local compare by value or by position
    always_comb begin
        if (ctrl.by_value) begin
            match_next = in_list && (value_reg == key);
        end else begin
            match_next = in_list && (pos == olde_pkg::POS_W'(CELL_INDEX));
        end
    end

    // entry storage, fed from the upper neighbour on delete
    always_ff @(posedge aclk) begin
        if (ctrl.delete_en && shift_en) begin
            value_reg <= upper_value;
        end else if (ctrl.append_en && at_tail) begin
            value_reg <= key;
        end
    end

    // match flag held for the apply step
    always_ff @(posedge aclk) begin
        if (ctrl.scan) begin
            match_reg <= match_next;
        end
    end

    assign value = value_reg;
    assign match = match_reg;

endmodule

[rtl/olde_pick.sv]
// lowest match pick: shift mask, hit position and hit word
module olde_pick #(
    parameter int CAPACITY = 64,
    parameter int IDX_W    = 6
) (
    input  logic [CAPACITY-1:0]         match_vec,
    input  logic [olde_pkg::DATA_W-1:0] values [CAPACITY],
    output logic [CAPACITY-1:0]         shift_mask,
    output logic                        any_hit,
    output logic [IDX_W-1:0]            hit_idx,
    output logic [olde_pkg::DATA_W-1:0] hit_value
);

    logic [CAPACITY-1:0] neg_match;
    logic [CAPACITY-1:0] first_hot;

    // two's complement keeps the lowest match and inverts every bit above it
    assign neg_match  = (~match_vec) + CAPACITY'(1);
    assign first_hot  = match_vec & neg_match;
    // every bit from the lowest match upwards
    assign shift_mask = match_vec | neg_match;
    assign any_hit    = |match_vec;

    // one-hot encode and and-or select of the picked entry
    always_comb begin
        hit_idx   = '0;
        hit_value = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (first_hot[i]) begin
                hit_idx   = hit_idx | IDX_W'(i);
                hit_value = hit_value | values[i];
            end
        end
    end

endmodule

[rtl/ordered_list_delete_engine.sv]
// top level of the ordered list delete engine: controller, cell chain, result register
//
//  channel | ports                                           | direction
//  --------+-------------------------------------------------+----------
//  command | s_valid s_ready s_command s_data_value s_position | in
//  result  | m_valid m_ready m_status m_hit_position           | out
//          | m_read_value m_entry_count                       |
//
// Every command passes a scan step where each cell compares its entry,
// then an apply step where the lowest match is picked and, on a delete,
// the cells above it shift down by one. The next command is taken in the apply step.
// Reset clears the entry count; cell contents stay as they were.
// A waiting result stalls the apply step, and with it the next command.
`include "ordered_list_delete_engine_defines.svh"
module ordered_list_delete_engine #(
    parameter int LIST_DEPTH = olde_pkg::LIST_DEPTH_DEFAULT
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [olde_pkg::CMD_W-1:0]           s_command,
    input  logic signed [olde_pkg::DATA_W-1:0]   s_data_value,
    input  logic [olde_pkg::POS_W-1:0]           s_position,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [olde_pkg::STATUS_W-1:0]        m_status,
    output logic [olde_pkg::POS_W-1:0]           m_hit_position,
    output logic signed [olde_pkg::DATA_W-1:0]   m_read_value,
    output logic [olde_pkg::ENTRY_W-1:0]         m_entry_count
);

    localparam int CAPACITY = (LIST_DEPTH < olde_pkg::MAX_CAPACITY) ?
                              LIST_DEPTH : olde_pkg::MAX_CAPACITY;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int COUNT_W  = $clog2(CAPACITY + 1);

    olde_pkg::state_t              state_reg, state_next;
    logic [olde_pkg::CMD_W-1:0]    cmd_reg;
    logic [olde_pkg::DATA_W-1:0]   key_reg;
    logic [olde_pkg::POS_W-1:0]    pos_reg;
    logic [COUNT_W-1:0]            count_reg, count_next;

    logic                          m_valid_reg, m_valid_next;
    olde_pkg::status_t             status_reg, status_next;
    logic [olde_pkg::POS_W-1:0]    hit_reg, hit_next;
    logic [olde_pkg::DATA_W-1:0]   rd_reg, rd_next;

    olde_pkg::cell_ctrl_t          ctrl;
    logic [olde_pkg::DATA_W-1:0]   cell_value [CAPACITY];
    logic [CAPACITY-1:0]           match_vec;
    logic [CAPACITY-1:0]           shift_mask;
    logic                          any_hit;
    logic [IDX_W-1:0]              hit_idx;
    logic [olde_pkg::DATA_W-1:0]   hit_value;

    logic                          s_accept;
    logic                          out_free;
    logic                          apply_go;
    logic                          is_full;
    logic                          do_delete;
    logic                          do_append;

    // handshake
    assign out_free = !m_valid_reg || m_ready;
    assign apply_go = (state_reg == olde_pkg::S_APPLY) && out_free;
    assign s_ready  = (state_reg == olde_pkg::S_IDLE) || apply_go;
    assign s_accept = s_valid && s_ready;

    // controller state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            olde_pkg::S_IDLE: begin
                if (s_valid) begin
                    state_next = olde_pkg::S_SCAN;
                end
            end
            olde_pkg::S_SCAN: begin
                state_next = olde_pkg::S_APPLY;
            end
            olde_pkg::S_APPLY: begin
                if (out_free) begin
                    state_next = s_valid ? olde_pkg::S_SCAN : olde_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = olde_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= olde_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // command word capture
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            cmd_reg <= s_command;
            key_reg <= s_data_value;
            pos_reg <= s_position;
        end
    end

    // result of the command in flight
    assign is_full = count_reg == COUNT_W'(CAPACITY);

    always_comb begin
        status_next = olde_pkg::ST_MISS;
        hit_next    = '0;
        rd_next     = '0;
        count_next  = count_reg;
        do_delete   = 1'b0;
        do_append   = 1'b0;
        unique case (cmd_reg)
            olde_pkg::CMD_APPEND: begin
                if (is_full) begin
                    status_next = olde_pkg::ST_FULL;
                end else begin
                    status_next = olde_pkg::ST_DONE;
                    hit_next    = olde_pkg::POS_W'(count_reg);
                    count_next  = count_reg + COUNT_W'(1);
                    do_append   = 1'b1;
                end
            end
            olde_pkg::CMD_DEL_VALUE, olde_pkg::CMD_DEL_POS: begin
                if (any_hit) begin
                    status_next = olde_pkg::ST_DONE;
                    hit_next    = olde_pkg::POS_W'(hit_idx);
                    rd_next     = hit_value;
                    count_next  = count_reg - COUNT_W'(1);
                    do_delete   = 1'b1;
                end
            end
            olde_pkg::CMD_READ_POS: begin
                if (any_hit) begin
                    status_next = olde_pkg::ST_DONE;
                    hit_next    = olde_pkg::POS_W'(hit_idx);
                    rd_next     = hit_value;
                end
            end
            olde_pkg::CMD_CLEAR: begin
                status_next = olde_pkg::ST_DONE;
                count_next  = '0;
            end
            default: begin
                status_next = olde_pkg::ST_MISS;
            end
        endcase
    end

    // entry count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (apply_go) begin
            count_reg <= count_next;
        end
    end

    // broadcast control to the cells
    assign ctrl.by_value  = cmd_reg == olde_pkg::CMD_DEL_VALUE;
    assign ctrl.scan      = state_reg == olde_pkg::S_SCAN;
    assign ctrl.delete_en = apply_go && do_delete;
    assign ctrl.append_en = apply_go && do_append;

    // cell chain, each cell fed by its upper neighbour
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        olde_cell #(
            .CELL_INDEX (g),
            .COUNT_W    (COUNT_W)
        ) u_cell (
            .aclk        (aclk),
            .ctrl        (ctrl),
            .count       (count_reg),
            .key         (key_reg),
            .pos         (pos_reg),
            .shift_en    (shift_mask[g]),
            .upper_value (cell_value[(g + 1 < CAPACITY) ? g + 1 : g]),
            .value       (cell_value[g]),
            .match       (match_vec[g])
        );
    end

    // lowest match pick
    olde_pick #(
        .CAPACITY (CAPACITY),
        .IDX_W    (IDX_W)
    ) u_pick (
        .match_vec  (match_vec),
        .values     (cell_value),
        .shift_mask (shift_mask),
        .any_hit    (any_hit),
        .hit_idx    (hit_idx),
        .hit_value  (hit_value)
    );

    // result register
    always_comb begin
        m_valid_next = m_valid_reg;
        if (apply_go) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (apply_go) begin
            status_reg <= status_next;
            hit_reg    <= hit_next;
            rd_reg     <= rd_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = status_reg;
    assign m_hit_position = hit_reg;
    assign m_read_value   = rd_reg;
    assign m_entry_count  = olde_pkg::ENTRY_W'(count_reg);

    // checks
    `OLDE_ASSERT_IMP(a_count_cap, 1'b1, count_reg <= COUNT_W'(CAPACITY), "count above capacity")
    `OLDE_ASSERT_IMP(a_pos_single, (state_reg == olde_pkg::S_APPLY) && !ctrl.by_value, $onehot0(match_vec), "several cells match one position")
    `OLDE_ASSERT_NEXT(a_accept_scan, s_accept, state_reg == olde_pkg::S_SCAN, "accepted word not scanned")
    `OLDE_ASSERT_NEXT(a_delete_count, ctrl.delete_en, count_reg == $past(count_reg) - COUNT_W'(1), "delete did not shrink the list")

endmodule
